/* rtl/core/nps2d_pkg.sv */
package nps2d_pkg;

    // Capacity of the point store
    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int OP_W       = 2;
    localparam int COORD_W    = 24;
    localparam int VAL_W      = 32;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = 49;
    localparam int OUT_IDX_W  = 10;

    // Stream widths
    localparam int S_FIELDS_W = 2 * COORD_W + 4 * VAL_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = OUT_IDX_W + DIST_W + 4 * VAL_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [VAL_W-1:0]   entropy;
        logic [VAL_W-1:0]   pressure;
        logic [VAL_W-1:0]   vel_x;
        logic [VAL_W-1:0]   vel_y;
    } cmd_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] index;
        logic [DIST_W-1:0]    dist_sq;
        logic [VAL_W-1:0]     entropy;
        logic [VAL_W-1:0]     pressure;
        logic [VAL_W-1:0]     vel_x;
        logic [VAL_W-1:0]     vel_y;
    } result_t;

endpackage

/* rtl/core/nps2d_front.sv */
module nps2d_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  nps2d_pkg::cmd_t    in_cmd,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output nps2d_pkg::cmd_t    cmd
);

    nps2d_pkg::cmd_t fifo_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      fill_reg;
    logic            op_known;
    logic            push;
    logic            pop;

    // Drop words with an unused operation code at the door
    assign op_known  = (in_cmd.op == nps2d_pkg::OP_LOAD) ||
                       (in_cmd.op == nps2d_pkg::OP_QUERY) ||
                       (in_cmd.op == nps2d_pkg::OP_CLEAR);
    assign in_ready  = (fill_reg != 2'd2);
    assign push      = in_valid && in_ready && op_known;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg != 2'd3)
        else $error("front queue fill out of range");

endmodule

/* rtl/core/nps2d_back.sv */
module nps2d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  nps2d_pkg::cmd_t     cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output nps2d_pkg::result_t  result
);

    localparam int CNT_W   = nps2d_pkg::CNT_W;
    localparam int IDX_W   = nps2d_pkg::IDX_W;
    localparam int COORD_W = nps2d_pkg::COORD_W;
    localparam int VAL_W   = nps2d_pkg::VAL_W;
    localparam int SQ_W    = nps2d_pkg::SQ_W;
    localparam int DIST_W  = nps2d_pkg::DIST_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FETCH, ST_RESULT} state_t;

    // Point store: coordinates scanned in order, values read once per query
    logic [2*COORD_W-1:0] coord_mem [nps2d_pkg::MAX_POINTS];
    logic [4*VAL_W-1:0]   val_mem   [nps2d_pkg::MAX_POINTS];
    logic [2*COORD_W-1:0] coord_rd_reg;
    logic [4*VAL_W-1:0]   val_rd_reg;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     issue_reg;
    logic                 empty_reg;
    logic                 best_valid_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [DIST_W-1:0]    best_dist_reg;
    logic                 out_valid_reg;
    nps2d_pkg::result_t   out_reg;

    logic [COORD_W-1:0]   qx_reg;
    logic [COORD_W-1:0]   qy_reg;
    logic                 p1_v_reg;
    logic                 p2_v_reg;
    logic                 p3_v_reg;
    logic [IDX_W-1:0]     p1_idx_reg;
    logic [IDX_W-1:0]     p2_idx_reg;
    logic [IDX_W-1:0]     p3_idx_reg;
    logic [COORD_W-1:0]   adx_reg;
    logic [COORD_W-1:0]   ady_reg;
    logic [SQ_W-1:0]      sqx_reg;
    logic [SQ_W-1:0]      sqy_reg;

    logic                 take;
    logic                 load_go;
    logic                 query_go;
    logic                 issue_go;
    logic                 scan_done;
    logic                 out_free;
    logic                 res_load;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic [COORD_W-1:0]   sx;
    logic [COORD_W-1:0]   sy;
    logic [COORD_W:0]     dx;
    logic [COORD_W:0]     dy;
    logic [COORD_W:0]     dx_abs;
    logic [COORD_W:0]     dy_abs;
    logic [DIST_W-1:0]    dist_sum;
    logic                 better;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign load_go   = take && (cmd.op == nps2d_pkg::OP_LOAD) &&
                       (count_reg < CNT_W'(nps2d_pkg::MAX_POINTS));
    assign query_go  = take && (cmd.op == nps2d_pkg::OP_QUERY);
    assign issue_go  = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign scan_done = (state_reg == ST_SCAN) && !issue_go &&
                       !p1_v_reg && !p2_v_reg && !p3_v_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign res_load  = (state_reg == ST_RESULT) && out_free;
    assign rd_addr   = issue_reg[IDX_W-1:0];
    assign wr_addr   = count_reg[IDX_W-1:0];

    assign sx     = coord_rd_reg[2*COORD_W-1:COORD_W];
    assign sy     = coord_rd_reg[COORD_W-1:0];
    assign dx     = {qx_reg[COORD_W-1], qx_reg} - {sx[COORD_W-1], sx};
    assign dy     = {qy_reg[COORD_W-1], qy_reg} - {sy[COORD_W-1], sy};
    assign dx_abs = dx[COORD_W] ? (~dx + 1'b1) : dx;
    assign dy_abs = dy[COORD_W] ? (~dy + 1'b1) : dy;

    assign dist_sum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
    assign better   = !best_valid_reg || (dist_sum < best_dist_reg);

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            coord_mem[wr_addr] <= {cmd.x, cmd.y};
            val_mem[wr_addr]   <= {cmd.entropy, cmd.pressure, cmd.vel_x, cmd.vel_y};
        end
        coord_rd_reg <= coord_mem[rd_addr];
        val_rd_reg   <= val_mem[best_idx_reg];
    end

    // Scan datapath: read, difference, square, then compare
    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            qx_reg <= cmd.x;
            qy_reg <= cmd.y;
        end
        p1_idx_reg <= rd_addr;
        p2_idx_reg <= p1_idx_reg;
        adx_reg    <= dx_abs[COORD_W-1:0];
        ady_reg    <= dy_abs[COORD_W-1:0];
        p3_idx_reg <= p2_idx_reg;
        sqx_reg    <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
        sqy_reg    <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            issue_reg      <= '0;
            empty_reg      <= 1'b0;
            best_valid_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_dist_reg  <= '0;
            p1_v_reg       <= 1'b0;
            p2_v_reg       <= 1'b0;
            p3_v_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            p1_v_reg <= issue_go;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;

            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        case (cmd.op)
                            nps2d_pkg::OP_LOAD:
                            begin
                                if (load_go)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            nps2d_pkg::OP_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            nps2d_pkg::OP_QUERY:
                            begin
                                issue_reg      <= '0;
                                best_valid_reg <= 1'b0;
                                best_idx_reg   <= '0;
                                empty_reg      <= (count_reg == '0);
                                state_reg      <= (count_reg == '0) ? ST_RESULT : ST_SCAN;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (issue_go)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    // Strict less-than keeps the lowest index on ties
                    if (p3_v_reg && better)
                    begin
                        best_valid_reg <= 1'b1;
                        best_dist_reg  <= dist_sum;
                        best_idx_reg   <= p3_idx_reg;
                    end
                    if (scan_done)
                    begin
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        if (empty_reg)
                        begin
                            out_reg <= '0;
                        end
                        else
                        begin
                            out_reg.found    <= 1'b1;
                            out_reg.index    <= nps2d_pkg::OUT_IDX_W'(best_idx_reg);
                            out_reg.dist_sq  <= best_dist_reg;
                            out_reg.entropy  <= val_rd_reg[4*VAL_W-1:3*VAL_W];
                            out_reg.pressure <= val_rd_reg[3*VAL_W-1:2*VAL_W];
                            out_reg.vel_x    <= val_rd_reg[2*VAL_W-1:VAL_W];
                            out_reg.vel_y    <= val_rd_reg[VAL_W-1:0];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(nps2d_pkg::MAX_POINTS))
        else $error("point count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        p3_v_reg |-> (state_reg == ST_SCAN))
        else $error("compare stage active outside scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && !empty_reg) |-> (best_valid_reg && (CNT_W'(best_idx_reg) < count_reg)))
        else $error("result taken without a valid best point");

endmodule

/* rtl/core/nearest_point_search_2d_core.sv */
// Channel  | Dir | Signals                          | Word
// ---------+-----+----------------------------------+--------------------------------------
// s        | in  | s_tvalid s_tready s_tdata s_tuser| load, query or clear command
// m        | out | m_tvalid m_tready m_tdata m_tuser| one nearest-point result per query
//
// Loads and clears are handled in the back end's idle state; an unused operation code is dropped.
// A query scans the point set one point per cycle through the coordinate memory read port
// and its four-stage distance pipeline; an empty set skips the scan and gives no match.
// A two-word queue sits in front, so up to two input words are taken while a query runs or
// while a result waits on m_tready; the output register holds the result until taken.
// Reset (rst_n low, asynchronous) empties the point set, the queue and the output register;
// the point memories are not cleared.
module nearest_point_search_2d_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // coord_x, coord_y, load_entropy, load_pressure, load_vel_x, load_vel_y
    input  logic [nps2d_pkg::S_DATA_W-1:0]   s_tdata,
    // operation
    input  logic [nps2d_pkg::OP_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // nearest_index, distance_squared, near_entropy, near_pressure, near_vel_x,
    // near_vel_y, zero pad
    output logic [nps2d_pkg::M_DATA_W-1:0]   m_tdata,
    // found
    output logic [0:0]                       m_tuser
);

    localparam int COORD_W = nps2d_pkg::COORD_W;
    localparam int VAL_W   = nps2d_pkg::VAL_W;
    localparam int V0      = 2 * COORD_W;

    nps2d_pkg::cmd_t    in_cmd;
    nps2d_pkg::cmd_t    cmd;
    nps2d_pkg::result_t result;
    logic               cmd_valid;
    logic               cmd_ready;

    // Unpack the input word, first field in the lowest bits
    always_comb
    begin
        in_cmd.op       = s_tuser;
        in_cmd.x        = s_tdata[COORD_W-1:0];
        in_cmd.y        = s_tdata[2*COORD_W-1:COORD_W];
        in_cmd.entropy  = s_tdata[V0+VAL_W-1:V0];
        in_cmd.pressure = s_tdata[V0+2*VAL_W-1:V0+VAL_W];
        in_cmd.vel_x    = s_tdata[V0+3*VAL_W-1:V0+2*VAL_W];
        in_cmd.vel_y    = s_tdata[V0+4*VAL_W-1:V0+3*VAL_W];
    end

    // Front end: classify and queue
    nps2d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back end: point store, scan and result register
    nps2d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    // Pack the result word, first field in the lowest bits
    assign m_tdata = {{(nps2d_pkg::M_DATA_W - nps2d_pkg::M_FIELDS_W){1'b0}},
                      result.vel_y, result.vel_x, result.pressure, result.entropy,
                      result.dist_sq, result.index};
    assign m_tuser = result.found;

endmodule
